FILE: sv/frame_change_blend_decider_core_macros.svh
// assertion macros shared by the frame change blend decider modules
// no dependencies; included inside modules that check their own logic
`ifndef FRAME_CHANGE_BLEND_DECIDER_CORE_MACROS_SVH
`define FRAME_CHANGE_BLEND_DECIDER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define FCBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcbd assertion failed");

// next-cycle implication, off during reset
`define FCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcbd assertion failed");

`endif

FILE: sv/fcbd_pkg.sv
// shared types and constants for the frame change blend decider
// no dependencies
package fcbd_pkg;

    localparam int DIFF_W      = 8;
    localparam int THR_W       = 24;
    localparam int SUM_W       = 25;
    localparam int HIST_DEPTH  = 3;
    localparam int COUNT_W     = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_SAT     = 2'd2;
    localparam logic [THR_W-1:0]   THR_RESET     = 24'd8;

    // register indexes, byte address divided by four
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MAX_NORM  = 2'd1;
    localparam logic [1:0] REG_SLOWDOWN  = 2'd2;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              last;
    } pixel_item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic             use_max_norm;
        logic             slowdown_fix;
    } cfg_t;

endpackage

FILE: sv/fcbd_front.sv
// front part: takes pixel pairs and reduces each to its largest channel difference
// depends on fcbd_pkg
module fcbd_front
(
    input  logic                  in_valid,
    input  logic [7:0]            first_blue,
    input  logic [7:0]            first_green,
    input  logic [7:0]            first_red,
    input  logic [7:0]            second_blue,
    input  logic [7:0]            second_green,
    input  logic [7:0]            second_red,
    input  logic                  last_pixel,
    input  fcbd_pkg::queue_status_t q_status,
    output logic                  in_stall,
    output logic                  push,
    output fcbd_pkg::pixel_item_t push_item
);

    logic [7:0] diff_b;
    logic [7:0] diff_g;
    logic [7:0] diff_r;
    logic [7:0] max_bg;

    always_comb
    begin
        diff_b = (first_blue  > second_blue)  ? first_blue  - second_blue
                                               : second_blue  - first_blue;
        diff_g = (first_green > second_green) ? first_green - second_green
                                               : second_green - first_green;
        diff_r = (first_red   > second_red)   ? first_red   - second_red
                                               : second_red   - first_red;
        max_bg = (diff_g > diff_b) ? diff_g : diff_b;
        push_item.diff = (diff_r > max_bg) ? diff_r : max_bg;
        push_item.last = last_pixel;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

FILE: sv/fcbd_queue.sv
// short queue of classified items between front and back
// depends on fcbd_pkg and the assertion macro header
module fcbd_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fcbd_pkg::pixel_item_t   push_item,
    input  logic                    pop,
    output fcbd_pkg::pixel_item_t   head_item,
    output fcbd_pkg::queue_status_t q_status
);

    fcbd_pkg::pixel_item_t          slot_reg [fcbd_pkg::QUEUE_DEPTH];
    logic [fcbd_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [fcbd_pkg::QUEUE_AW-1:0]  wr_ptr_next;
    logic [fcbd_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [fcbd_pkg::QUEUE_AW-1:0]  rd_ptr_next;
    logic [fcbd_pkg::QUEUE_CW-1:0]  count_reg;
    logic [fcbd_pkg::QUEUE_CW-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item          = slot_reg[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.full      = (count_reg == fcbd_pkg::QUEUE_CW'(fcbd_pkg::QUEUE_DEPTH));

`include "frame_change_blend_decider_core_macros.svh"

    `FCBD_ASSERT_NOW(a_q_no_overflow, clk, rst_n, push, !q_status.full)
    `FCBD_ASSERT_NOW(a_q_no_underflow, clk, rst_n, pop, q_status.not_empty)
    `FCBD_ASSERT_NOW(a_q_count_bound, clk, rst_n, 1'b1,
        count_reg <= fcbd_pkg::QUEUE_CW'(fcbd_pkg::QUEUE_DEPTH))

endmodule

FILE: sv/fcbd_back.sv
// back part: accumulates the change flag, keeps flag history, decides blend or copy
// depends on fcbd_pkg and the assertion macro header
module fcbd_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fcbd_pkg::cfg_t          cfg,
    input  fcbd_pkg::pixel_item_t   head_item,
    input  fcbd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    pair_differs,
    output logic                    decision_valid,
    output logic                    blend_frames
);

    logic [fcbd_pkg::SUM_W-1:0]      diff_sum_reg;
    logic [fcbd_pkg::SUM_W-1:0]      diff_sum_next;
    logic                            change_found_reg;
    logic                            change_found_next;
    logic [fcbd_pkg::HIST_DEPTH-1:0] hist_reg;
    logic [fcbd_pkg::HIST_DEPTH-1:0] hist_next;
    logic [fcbd_pkg::COUNT_W-1:0]    count_reg;
    logic [fcbd_pkg::COUNT_W-1:0]    count_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            differs_reg;
    logic                            dvalid_reg;
    logic                            blend_reg;

    logic [fcbd_pkg::SUM_W:0]        sum_wide;
    logic [fcbd_pkg::SUM_W-1:0]      sum_sat;
    logic                            hit;
    logic                            flag;
    logic                            dvalid;
    logic                            blend;
    logic                            finish;

    assign pop    = q_status.not_empty && (!head_item.last || !out_valid_reg || !out_stall);
    assign finish = pop && head_item.last;

    always_comb
    begin
        sum_wide = {1'b0, diff_sum_reg}
                 + (fcbd_pkg::SUM_W+1)'(head_item.diff);
        sum_sat  = sum_wide[fcbd_pkg::SUM_W] ? fcbd_pkg::SUM_MAX
                                             : sum_wide[fcbd_pkg::SUM_W-1:0];
        if (cfg.use_max_norm)
        begin
            hit = (fcbd_pkg::THR_W'(head_item.diff) >= cfg.threshold);
        end
        else
        begin
            hit = (sum_sat >= fcbd_pkg::SUM_W'(cfg.threshold));
        end
        flag   = change_found_reg || hit;
        dvalid = (count_reg == fcbd_pkg::COUNT_SAT);
        blend  = dvalid && (hist_reg[1] ||
                 (cfg.slowdown_fix && !hist_reg[2] && hist_reg[0] && !flag));
    end

    always_comb
    begin
        diff_sum_next     = diff_sum_reg;
        change_found_next = change_found_reg;
        hist_next         = hist_reg;
        count_next        = count_reg;
        if (pop)
        begin
            if (head_item.last)
            begin
                diff_sum_next     = '0;
                change_found_next = 1'b0;
                hist_next         = {hist_reg[1:0], flag};
                if (count_reg != fcbd_pkg::COUNT_SAT)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                change_found_next = flag;
                if (!change_found_reg && !cfg.use_max_norm)
                begin
                    diff_sum_next = sum_sat;
                end
            end
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_sum_reg     <= '0;
            change_found_reg <= 1'b0;
            hist_reg         <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            diff_sum_reg     <= diff_sum_next;
            change_found_reg <= change_found_next;
            hist_reg         <= hist_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            differs_reg <= flag;
            dvalid_reg  <= dvalid;
            blend_reg   <= blend;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pair_differs   = differs_reg;
    assign decision_valid = dvalid_reg;
    assign blend_frames   = blend_reg;

`include "frame_change_blend_decider_core_macros.svh"

    `FCBD_ASSERT_NEXT(a_last_gives_result, clk, rst_n, finish, out_valid_reg)
    `FCBD_ASSERT_NOW(a_blend_needs_decision, clk, rst_n, out_valid_reg && blend_reg, dvalid_reg)
    `FCBD_ASSERT_NEXT(a_stalled_result_not_replaced, clk, rst_n,
        out_valid_reg && out_stall, out_valid_reg)

endmodule

FILE: sv/frame_change_blend_decider_core.sv
// top level of the frame change blend decider: config registers, front, queue, back
// depends on fcbd_pkg, fcbd_front, fcbd_queue, fcbd_back
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_stall    | first_*, second_* bytes, last_pixel
//  output   | out_valid / out_stall  | pair_differs, decision_valid, blend_frames
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// one pixel pair accepted per cycle unless stalled; a result is registered as its last pixel pops
// the back part retires one queued item per cycle if any, held only by a stalled result
// in_stall rises when the four-entry queue is full; no clearing pass after reset
module frame_change_blend_decider_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    first_blue,
    input  logic [7:0]                    first_green,
    input  logic [7:0]                    first_red,
    input  logic [7:0]                    second_blue,
    input  logic [7:0]                    second_green,
    input  logic [7:0]                    second_red,
    input  logic                          last_pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pair_differs,
    output logic                          decision_valid,
    output logic                          blend_frames,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [fcbd_pkg::DATA_W-1:0]   pwdata,
    output logic [fcbd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    fcbd_pkg::cfg_t          cfg_reg;
    fcbd_pkg::cfg_t          cfg_next;
    fcbd_pkg::queue_status_t q_status;
    fcbd_pkg::pixel_item_t   push_item;
    fcbd_pkg::pixel_item_t   head_item;
    logic                    push;
    logic                    pop;
    logic                    cfg_write;
    logic [1:0]              reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                fcbd_pkg::REG_THRESHOLD: cfg_next.threshold    = pwdata[fcbd_pkg::THR_W-1:0];
                fcbd_pkg::REG_MAX_NORM:  cfg_next.use_max_norm = pwdata[0];
                fcbd_pkg::REG_SLOWDOWN:  cfg_next.slowdown_fix = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            fcbd_pkg::REG_THRESHOLD: prdata = fcbd_pkg::DATA_W'(cfg_reg.threshold);
            fcbd_pkg::REG_MAX_NORM:  prdata = fcbd_pkg::DATA_W'(cfg_reg.use_max_norm);
            fcbd_pkg::REG_SLOWDOWN:  prdata = fcbd_pkg::DATA_W'(cfg_reg.slowdown_fix);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= fcbd_pkg::THR_RESET;
            cfg_reg.use_max_norm <= 1'b1;
            cfg_reg.slowdown_fix <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fcbd_front u_front
    (
        .in_valid     (in_valid),
        .first_blue   (first_blue),
        .first_green  (first_green),
        .first_red    (first_red),
        .second_blue  (second_blue),
        .second_green (second_green),
        .second_red   (second_red),
        .last_pixel   (last_pixel),
        .q_status     (q_status),
        .in_stall     (in_stall),
        .push         (push),
        .push_item    (push_item)
    );

    fcbd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    fcbd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head_item      (head_item),
        .q_status       (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pair_differs   (pair_differs),
        .decision_valid (decision_valid),
        .blend_frames   (blend_frames)
    );

endmodule
